// ----- sv/pntcs_pkg.sv -----
// ============================================================================
// pntcs_pkg - shared types and constants for the packed-nibble column span
// Command codes, queue entry layout and sizing used by front, queue and back.
// ============================================================================
package pntcs_pkg;

  // Texel store size in bytes and its address width
  localparam int TEXEL_BYTES = 2048;
  localparam int TEX_AW      = $clog2(TEXEL_BYTES);

  // Longest span drawn; longer requests are clipped
  localparam int MAX_SPAN = 64;

  // Palette
  localparam int PAL_DEPTH = 16;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  // Command queue depth (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Field widths
  localparam int LOC_W   = 11;
  localparam int DATA_W  = 16;
  localparam int COORD_W = 10;
  localparam int POS_W   = 32;
  localparam int LEN_W   = 7;
  localparam int ADDR_W  = 21;
  localparam int PITCH_W = 11;
  localparam int CNT_W   = 32;

  // Texture position layout: byte index from bit 13 up, nibble select bit 12
  localparam int BYTE_LSB = 13;
  localparam int NIB_BIT  = 12;

  // Item kind codes on the input port
  localparam logic [1:0] KIND_TEX   = 2'd0;
  localparam logic [1:0] KIND_PAL   = 2'd1;
  localparam logic [1:0] KIND_DRAW  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // APB register indexes
  localparam logic REG_PITCH = 1'b0;
  localparam logic REG_WALL  = 1'b1;

  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(256);

  typedef enum logic [1:0] {
    OP_TEX,
    OP_PAL,
    OP_DRAW,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [LOC_W-1:0]    location;
    logic [DATA_W-1:0]   data;
    logic [ADDR_W-1:0]   addr;
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    step;
    logic [LEN_W-1:0]    length;
  } cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- sv/pntcs_ram.sv -----
// ============================================================================
// pntcs_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
module pntcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pntcs_front.sv -----
// ============================================================================
// pntcs_front - item intake and classification
// Decodes the item kind, drops items with no effect, clips the span length
// and forms the first frame-buffer address before queueing the command.
// ============================================================================
module pntcs_front (
  input  logic                              start,
  input  pntcs_pkg::q_stat_t                q_stat,
  input  logic [1:0]                        kind,
  input  logic [pntcs_pkg::LOC_W-1:0]       location,
  input  logic [pntcs_pkg::DATA_W-1:0]      load_data,
  input  logic [pntcs_pkg::COORD_W-1:0]     start_x,
  input  logic [pntcs_pkg::COORD_W-1:0]     start_y,
  input  logic [pntcs_pkg::POS_W-1:0]       texel_position,
  input  logic [pntcs_pkg::POS_W-1:0]       texel_step,
  input  logic [pntcs_pkg::LEN_W-1:0]       span_length,
  input  logic [pntcs_pkg::PITCH_W-1:0]     row_pitch,
  input  logic                              wall_active,
  output logic                              busy,
  output logic                              push,
  output pntcs_pkg::cmd_t                   cmd
);

  logic                           accept;
  logic                           keep;
  logic [pntcs_pkg::ADDR_W-1:0]   row_base;
  logic [pntcs_pkg::LEN_W-1:0]    len_clip;

  assign busy   = q_stat.full;
  assign accept = start && !busy;

  assign row_base = pntcs_pkg::ADDR_W'(start_y) * pntcs_pkg::ADDR_W'(row_pitch);
  assign len_clip = (32'(span_length) > pntcs_pkg::MAX_SPAN) ?
                    pntcs_pkg::LEN_W'(pntcs_pkg::MAX_SPAN) : span_length;

  always_comb begin
    cmd.location = location;
    cmd.data     = load_data;
    cmd.addr     = row_base + pntcs_pkg::ADDR_W'(start_x);
    cmd.pos      = texel_position;
    cmd.step     = texel_step;
    cmd.length   = len_clip;
    unique case (kind)
      pntcs_pkg::KIND_TEX: begin
        cmd.op = pntcs_pkg::OP_TEX;
        keep   = 32'(location) < pntcs_pkg::TEXEL_BYTES;
      end
      pntcs_pkg::KIND_PAL: begin
        cmd.op = pntcs_pkg::OP_PAL;
        keep   = 32'(location) < pntcs_pkg::PAL_DEPTH;
      end
      pntcs_pkg::KIND_DRAW: begin
        cmd.op = pntcs_pkg::OP_DRAW;
        keep   = wall_active && (span_length != '0);
      end
      default: begin
        cmd.op = pntcs_pkg::OP_CLEAR;
        keep   = 1'b1;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

// ----- sv/pntcs_queue.sv -----
// ============================================================================
// pntcs_queue - short command queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ============================================================================
module pntcs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pntcs_pkg::cmd_t    push_cmd,
  input  logic               pop,
  output pntcs_pkg::cmd_t    head,
  output pntcs_pkg::q_stat_t q_stat
);

  localparam int AW = pntcs_pkg::QUEUE_AW;

  pntcs_pkg::cmd_t entries [pntcs_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic [AW-1:0]   wr_ptr_next;
  logic [AW-1:0]   rd_ptr_next;
  logic [AW:0]     count_next;

  assign q_stat.full  = (count == (AW+1)'(pntcs_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == AW'(pntcs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == AW'(pntcs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- sv/pntcs_back.sv -----
// ============================================================================
// pntcs_back - command execution and span walker
// Stores loads, clears counters, and walks a span one pixel per cycle
// through texel RAM read, palette lookup and the result register.
// ============================================================================
module pntcs_back (
  input  logic                            clk,
  input  logic                            rst,
  input  pntcs_pkg::cmd_t                 head,
  input  pntcs_pkg::q_stat_t              q_stat,
  input  logic [pntcs_pkg::PITCH_W-1:0]   row_pitch,
  output logic                            pop,
  output logic                            strobe,
  output logic [pntcs_pkg::ADDR_W-1:0]    pixel_address,
  output logic [pntcs_pkg::DATA_W-1:0]    color,
  output logic                            range_error,
  output logic                            last,
  output logic [pntcs_pkg::CNT_W-1:0]     spans_total,
  output logic [pntcs_pkg::CNT_W-1:0]     pixels_total,
  output logic [pntcs_pkg::CNT_W-1:0]     errors_total
);

  localparam int TAW = pntcs_pkg::TEX_AW;

  // walker stage
  logic                           walk_active;
  logic                           walk_first;
  logic [pntcs_pkg::POS_W-1:0]    walk_pos;
  logic [pntcs_pkg::POS_W-1:0]    walk_step;
  logic [pntcs_pkg::ADDR_W-1:0]   walk_addr;
  logic [pntcs_pkg::LEN_W-1:0]    walk_left;
  logic                           walk_err;
  logic                           walk_last;

  // lookup stage
  logic                           b_valid;
  logic                           b_first;
  logic                           b_err;
  logic                           b_last;
  logic                           b_sel;
  logic [pntcs_pkg::ADDR_W-1:0]   b_addr;

  logic [7:0]                     tex_rdata;
  logic [3:0]                     nib;
  logic [pntcs_pkg::DATA_W-1:0]   palette [pntcs_pkg::PAL_DEPTH];
  logic                           do_tex;
  logic                           do_pal;
  logic                           do_draw;
  logic                           do_clear;

  // clear waits until in-flight pixels have been counted
  assign pop = !q_stat.empty && !walk_active &&
               !(head.op == pntcs_pkg::OP_CLEAR && b_valid);

  assign do_tex   = pop && (head.op == pntcs_pkg::OP_TEX);
  assign do_pal   = pop && (head.op == pntcs_pkg::OP_PAL);
  assign do_draw  = pop && (head.op == pntcs_pkg::OP_DRAW);
  assign do_clear = pop && (head.op == pntcs_pkg::OP_CLEAR);

  assign walk_err  = walk_pos[pntcs_pkg::POS_W-1] ||
                     (32'(walk_pos[pntcs_pkg::POS_W-2:pntcs_pkg::BYTE_LSB]) >=
                      pntcs_pkg::TEXEL_BYTES);
  assign walk_last = walk_err || (walk_left == pntcs_pkg::LEN_W'(1));

  pntcs_ram #(
    .WIDTH (8),
    .DEPTH (pntcs_pkg::TEXEL_BYTES)
  ) u_texel_ram (
    .clk   (clk),
    .we    (do_tex),
    .waddr (TAW'(head.location)),
    .wdata (head.data[7:0]),
    .raddr (walk_pos[pntcs_pkg::BYTE_LSB +: TAW]),
    .rdata (tex_rdata)
  );

  always_ff @(posedge clk) begin
    if (do_pal) begin
      palette[head.location[pntcs_pkg::PAL_AW-1:0]] <= head.data;
    end
  end

  // walker control
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active <= 1'b0;
      b_valid     <= 1'b0;
    end else begin
      if (do_draw) begin
        walk_active <= 1'b1;
      end else if (walk_active && walk_last) begin
        walk_active <= 1'b0;
      end
      b_valid <= walk_active;
    end
  end

  // walker datapath
  always_ff @(posedge clk) begin
    if (do_draw) begin
      walk_pos   <= head.pos;
      walk_step  <= head.step;
      walk_addr  <= head.addr;
      walk_left  <= head.length;
      walk_first <= 1'b1;
    end else if (walk_active) begin
      walk_pos   <= walk_pos + walk_step;
      walk_addr  <= walk_addr + pntcs_pkg::ADDR_W'(row_pitch);
      walk_left  <= walk_left - 1'b1;
      walk_first <= 1'b0;
    end
    b_first <= walk_first;
    b_err   <= walk_err;
    b_last  <= walk_last;
    b_sel   <= walk_pos[pntcs_pkg::NIB_BIT];
    b_addr  <= walk_addr;
  end

  assign nib = b_sel ? tex_rdata[7:4] : tex_rdata[3:0];

  // result register and running counters
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe       <= 1'b0;
      spans_total  <= '0;
      pixels_total <= '0;
      errors_total <= '0;
    end else begin
      strobe <= b_valid;
      if (do_clear) begin
        spans_total  <= '0;
        pixels_total <= '0;
        errors_total <= '0;
      end else if (b_valid) begin
        if (b_first) begin
          spans_total <= spans_total + 1'b1;
        end
        if (b_err) begin
          errors_total <= errors_total + 1'b1;
        end else begin
          pixels_total <= pixels_total + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pixel_address <= b_addr;
    color         <= b_err ? '0 : palette[nib];
    range_error   <= b_err;
    last          <= b_last;
  end

endmodule

// ----- sv/packed_nibble_texture_column_span.sv -----
// ============================================================================
// packed_nibble_texture_column_span - vertical span drawer, 4-bit texture
// Loads a packed nibble texel store and a 16-entry RGB565 palette, then walks
// frame-buffer columns emitting one palette color per pixel (zero on a range
// error) with counters.
//
// Channel   Handshake                     Payload
// --------  ----------------------------  -------------------------------------
// item in   start & !busy                 kind, location, load_data, start_x,
//                                         start_y, texel_position, texel_step,
//                                         span_length
// result    strobe (one cycle, no stall)  pixel_address, color, range_error,
//                                         last, spans_total, pixels_total,
//                                         errors_total
// config    APB psel/penable/pwrite       0x0 row_pitch, 0x4 wall_active
//
// Flow: the front takes an item per cycle, while the queue is not full, into
// a two-entry command queue; busy is high only while that queue is full. The
// back runs one command at a time; a draw of n pixels (n clipped to 64) walks
// the span one pixel per texel RAM read. A span ended by a range error stops
// at the error pixel. Results pass from the walker registers through the RAM
// read and lookup registers to the result register. A clear waits for
// in-flight pixels. Reset (synchronous, active high) empties the queue, stops
// the walker, zeroes counters and sets row_pitch 256, wall_active 0. Texel and
// palette stores are not cleared.
//
module packed_nibble_texture_column_span (
  input  logic                             clk,
  input  logic                             rst,
  // item input
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       kind,
  input  logic [pntcs_pkg::LOC_W-1:0]      location,
  input  logic [pntcs_pkg::DATA_W-1:0]     load_data,
  input  logic [pntcs_pkg::COORD_W-1:0]    start_x,
  input  logic [pntcs_pkg::COORD_W-1:0]    start_y,
  input  logic [pntcs_pkg::POS_W-1:0]      texel_position,
  input  logic [pntcs_pkg::POS_W-1:0]      texel_step,
  input  logic [pntcs_pkg::LEN_W-1:0]      span_length,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // results
  output logic                             strobe,
  output logic [pntcs_pkg::ADDR_W-1:0]     pixel_address,
  output logic [pntcs_pkg::DATA_W-1:0]     color,
  output logic                             range_error,
  output logic                             last,
  output logic [pntcs_pkg::CNT_W-1:0]      spans_total,
  output logic [pntcs_pkg::CNT_W-1:0]      pixels_total,
  output logic [pntcs_pkg::CNT_W-1:0]      errors_total
);

  logic [pntcs_pkg::PITCH_W-1:0] row_pitch;
  logic                          wall_active;
  logic                          cfg_write;

  logic                          push;
  logic                          pop;
  pntcs_pkg::cmd_t               push_cmd;
  pntcs_pkg::cmd_t               head;
  pntcs_pkg::q_stat_t            q_stat;

  // --- configuration registers; word address decode on paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch   <= pntcs_pkg::PITCH_RESET;
      wall_active <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == pntcs_pkg::REG_PITCH) begin
        row_pitch <= pwdata[pntcs_pkg::PITCH_W-1:0];
      end else begin
        wall_active <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == pntcs_pkg::REG_WALL) begin
      prdata = {31'b0, wall_active};
    end else begin
      prdata = {{(32 - pntcs_pkg::PITCH_W){1'b0}}, row_pitch};
    end
  end

  // --- front: accept and classify
  pntcs_front u_front (
    .start          (start),
    .q_stat         (q_stat),
    .kind           (kind),
    .location       (location),
    .load_data      (load_data),
    .start_x        (start_x),
    .start_y        (start_y),
    .texel_position (texel_position),
    .texel_step     (texel_step),
    .span_length    (span_length),
    .row_pitch      (row_pitch),
    .wall_active    (wall_active),
    .busy           (busy),
    .push           (push),
    .cmd            (push_cmd)
  );

  // --- command queue
  pntcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // --- back: execute loads, clears and spans
  pntcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .row_pitch     (row_pitch),
    .pop           (pop),
    .strobe        (strobe),
    .pixel_address (pixel_address),
    .color         (color),
    .range_error   (range_error),
    .last          (last),
    .spans_total   (spans_total),
    .pixels_total  (pixels_total),
    .errors_total  (errors_total)
  );

endmodule

// ----- verif/packed_nibble_texture_column_span_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// packed_nibble_texture_column_span_tb - self-checking bench for the span drawer
// Fills both ends of the texel store and the whole palette, runs a table of
// edge-case items, then random phases under several row pitches and wall
// settings. Every pixel result is checked field by field against a prediction.
// ============================================================================
module packed_nibble_texture_column_span_tb;
  import pntcs_pkg::*;

  // --------------------------------------------------------------------------
  // Item and result records
  // --------------------------------------------------------------------------
  typedef struct packed {
    op_t                kind;
    logic [LOC_W-1:0]   location;
    logic [DATA_W-1:0]  load_data;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   step;
    logic [LEN_W-1:0]   len;
  } span_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] color;
    logic              err;
    logic              last_flag;
    logic [CNT_W-1:0]  spans;
    logic [CNT_W-1:0]  pixels;
    logic [CNT_W-1:0]  errs;
  } pixel_t;

  // Directed row: the item, plus an optional hand-written result. Rows with
  // typed set make exactly one result, and that result always carries last.
  typedef struct packed {
    op_t                kind;
    logic [LOC_W-1:0]   location;
    logic [DATA_W-1:0]  load_data;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   step;
    logic [LEN_W-1:0]   len;
    logic               typed;
    logic [ADDR_W-1:0]  e_addr;
    logic [DATA_W-1:0]  e_color;
    logic               e_err;
    logic [CNT_W-1:0]   e_spans;
    logic [CNT_W-1:0]   e_pixels;
    logic [CNT_W-1:0]   e_errs;
  } span_row_t;

  localparam int DIR_ROWS = 24;

  // Texel bytes loaded before any draw: the bottom and the top of the store.
  // Every draw the bench makes reads only inside these two windows.
  localparam int FILL_LOW  = 64;
  localparam int FILL_HIGH = 32;

  // Runs right after the store fill, with row pitch still at its reset value
  // of 256 and the wall turned on. Texel and palette contents are random
  // until rows further down pin a few entries.
  span_row_t dir_tab [0:DIR_ROWS-1] = '{
    // clear, so the typed counters below start from zero
    '{OP_CLEAR, 11'd0, 16'd0, 10'd0, 10'd0, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // negative start position: one error result, nothing drawn
    '{OP_DRAW, 11'd0, 16'd0, 10'd0, 10'd0, 32'h8000_0000, 32'd0, 7'd5,
      1'b1, 21'd0, 16'd0, 1'b1, 32'd1, 32'd0, 32'd1},
    // first byte past the store, at the far corner of the frame
    '{OP_DRAW, 11'd0, 16'd0, 10'd1023, 10'd1023, 32'h0100_0000, 32'd0, 7'd64,
      1'b1, 21'd262911, 16'd0, 1'b1, 32'd2, 32'd0, 32'd2},
    // largest positive position, overlong length
    '{OP_DRAW, 11'd0, 16'd0, 10'd5, 10'd2, 32'h7FFF_FFFF, 32'd0, 7'd127,
      1'b1, 21'd517, 16'd0, 1'b1, 32'd3, 32'd0, 32'd3},
    '{OP_DRAW, 11'd0, 16'd0, 10'd0, 10'd0, 32'hFFFF_FFFF, 32'd0, 7'd1,
      1'b1, 21'd0, 16'd0, 1'b1, 32'd4, 32'd0, 32'd4},
    // empty span: no result, no count
    '{OP_DRAW, 11'd0, 16'd0, 10'd7, 10'd7, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // palette index out of range is dropped
    '{OP_PAL, 11'd16, 16'hFFFF, 10'd0, 10'd0, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{OP_PAL, 11'd2047, 16'h1234, 10'd0, 10'd0, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{OP_PAL, 11'd15, 16'hFFFF, 10'd0, 10'd0, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{OP_PAL, 11'd0, 16'h0000, 10'd0, 10'd0, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // texel loads keep only the low byte
    '{OP_TEX, 11'd2047, 16'hFFFF, 10'd0, 10'd0, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{OP_TEX, 11'd0, 16'hFF00, 10'd0, 10'd0, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{OP_CLEAR, 11'd0, 16'd0, 10'd0, 10'd0, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // last byte, high nibble 0xF -> palette 15
    '{OP_DRAW, 11'd0, 16'd0, 10'd1023, 10'd0, 32'h00FF_F000, 32'd0, 7'd1,
      1'b1, 21'd1023, 16'hFFFF, 1'b0, 32'd1, 32'd1, 32'd0},
    // byte 0, low nibble 0 -> palette 0
    '{OP_DRAW, 11'd0, 16'd0, 10'd0, 10'd1023, 32'd0, 32'd0, 7'd1,
      1'b1, 21'd261888, 16'h0000, 1'b0, 32'd2, 32'd2, 32'd0},
    // nibble alternation
    '{OP_DRAW, 11'd0, 16'd0, 10'd10, 10'd3, 32'd0, 32'h0000_1000, 7'd8,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // largest valid position, held
    '{OP_DRAW, 11'd0, 16'd0, 10'd1, 10'd1, 32'h00FF_FFFF, 32'd0, 7'd3,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // walks off the top of the store on the second pixel
    '{OP_DRAW, 11'd0, 16'd0, 10'd2, 10'd9, 32'h00FF_E000, 32'h0000_2000, 7'd4,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // overlong span clipped to 64 pixels
    '{OP_DRAW, 11'd0, 16'd0, 10'd100, 10'd50, 32'd0, 32'h0000_0100, 7'd127,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // negative step drives the position below zero
    '{OP_DRAW, 11'd0, 16'd0, 10'd3, 10'd4, 32'h0000_4000, 32'hFFFF_F000, 7'd8,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // extreme steps flip the sign bit on the second pixel
    '{OP_DRAW, 11'd0, 16'd0, 10'd8, 10'd8, 32'h0000_0010, 32'h7FFF_FFFF, 7'd2,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{OP_DRAW, 11'd0, 16'd0, 10'd9, 10'd9, 32'd0, 32'h8000_0000, 7'd3,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // full span, position counting down from the top
    '{OP_DRAW, 11'd0, 16'd0, 10'd1023, 10'd1023, 32'h00FF_FFFF, 32'hFFFF_FFFF,
      7'd64, 1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{OP_CLEAR, 11'd0, 16'd0, 10'd0, 10'd0, 32'd0, 32'd0, 7'd0,
      1'b0, 21'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0}
  };

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst            = 1'b1;
  logic                start          = 1'b0;
  logic                busy;
  logic [1:0]          kind           = KIND_TEX;
  logic [LOC_W-1:0]    location       = '0;
  logic [DATA_W-1:0]   load_data      = '0;
  logic [COORD_W-1:0]  start_x        = '0;
  logic [COORD_W-1:0]  start_y        = '0;
  logic [POS_W-1:0]    texel_position = '0;
  logic [POS_W-1:0]    texel_step     = '0;
  logic [LEN_W-1:0]    span_length    = '0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [2:0]          paddr          = '0;
  logic [31:0]         pwdata         = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                strobe;
  logic [ADDR_W-1:0]   pixel_address;
  logic [DATA_W-1:0]   color;
  logic                range_error;
  logic                last;
  logic [CNT_W-1:0]    spans_total;
  logic [CNT_W-1:0]    pixels_total;
  logic [CNT_W-1:0]    errors_total;

  packed_nibble_texture_column_span u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .location       (location),
    .load_data      (load_data),
    .start_x        (start_x),
    .start_y        (start_y),
    .texel_position (texel_position),
    .texel_step     (texel_step),
    .span_length    (span_length),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .strobe         (strobe),
    .pixel_address  (pixel_address),
    .color          (color),
    .range_error    (range_error),
    .last           (last),
    .spans_total    (spans_total),
    .pixels_total   (pixels_total),
    .errors_total   (errors_total)
  );

  // 50 MHz
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow state of the block: stores, counters, registers
  // --------------------------------------------------------------------------
  logic [7:0]         texel_copy   [TEXEL_BYTES];
  logic [DATA_W-1:0]  palette_copy [PAL_DEPTH];
  logic [CNT_W-1:0]   span_count  = '0;
  logic [CNT_W-1:0]   pixel_count = '0;
  logic [CNT_W-1:0]   error_count = '0;
  logic [PITCH_W-1:0] pitch_copy  = PITCH_RESET;
  logic               wall_copy   = 1'b0;

  pixel_t pending_pixels [$];   // pixel results still owed by the block

  int sender_idle   = 36;       // percent of cycles the sender holds back
  int mismatches    = 0;
  int items_sent    = 0;
  int draws_sent    = 0;
  int results_seen  = 0;
  int err_results   = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic owe_pixel(input bit keep, input logic [31:0] addr,
                           input logic [DATA_W-1:0] col, input logic err,
                           input logic fin);
    if (keep)
      pending_pixels.push_back(pixel_t'{addr[ADDR_W-1:0], col, err, fin,
                                        span_count, pixel_count, error_count});
  endtask

  // Applies one accepted item to the shadow state and queues the pixels it
  // owes. keep=0 updates the state only (the caller supplies the result).
  task automatic render_expected(input span_item_t it, input bit keep);
    logic [31:0] p;
    logic [31:0] bidx;
    logic [31:0] a;
    logic [3:0]  nib;
    int          n;
    case (it.kind)
      // location is 11 bits, so it always lands inside the store
      OP_TEX: texel_copy[it.location] = it.load_data[7:0];
      OP_PAL: begin
        if (it.location < PAL_DEPTH)
          palette_copy[it.location[PAL_AW-1:0]] = it.load_data;
      end
      OP_CLEAR: begin
        span_count  = '0;
        pixel_count = '0;
        error_count = '0;
      end
      default: begin
        // wall off or zero length: nothing drawn, nothing counted
        if (wall_copy && it.len != 0) begin
          n = (it.len > MAX_SPAN) ? MAX_SPAN : int'(it.len);
          span_count++;
          a = 32'(it.sy) * 32'(pitch_copy) + 32'(it.sx);
          p = it.pos;
          for (int i = 0; i < n; i++) begin
            bidx = p >> BYTE_LSB;
            // out of range ends the span with a single error pixel
            if (p[POS_W-1] || bidx >= TEXEL_BYTES) begin
              error_count++;
              owe_pixel(keep, a, '0, 1'b1, 1'b1);
              break;
            end
            nib = p[NIB_BIT] ? texel_copy[bidx[TEX_AW-1:0]][7:4]
                             : texel_copy[bidx[TEX_AW-1:0]][3:0];
            pixel_count++;
            owe_pixel(keep, a, palette_copy[nib], 1'b0, i == n - 1);
            a = a + 32'(pitch_copy);
            p = p + it.step;
          end
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Item driver: random hold-off, then start until busy lets it through
  // --------------------------------------------------------------------------
  task automatic send_item(input span_item_t it, input bit keep);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    kind           <= it.kind;
    location       <= it.location;
    load_data      <= it.load_data;
    start_x        <= it.sx;
    start_y        <= it.sy;
    texel_position <= it.pos;
    texel_step     <= it.step;
    span_length    <= it.len;
    @(posedge clk);
    while (busy) @(posedge clk);
    render_expected(it, keep);
    items_sent++;
    if (it.kind == OP_DRAW) draws_sent++;
  endtask

  // Stop sending, wait for all owed pixels (bounded), flag any that never
  // came, then let the block settle: queued loads and clears may still be
  // in flight.
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_pixels.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    while (pending_pixels.size() != 0) begin
      report_mismatch($sformatf("missing result for address %0h",
                                pending_pixels[0].addr));
      void'(pending_pixels.pop_front());
    end
    repeat (100) @(posedge clk);
  endtask

  // APB write: setup, access, done when pready is seen in the access phase.
  // psel drops before the task returns so back-to-back writes never touch psel twice in a step.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PITCH) pitch_copy = value[PITCH_W-1:0];
    else                  wall_copy  = value[0];
    @(posedge clk);
  endtask

  // One random phase under a fixed register setting. Draws are mostly
  // in-range walks with small steps that stay inside the filled windows;
  // the rest is raw noise that always starts out of range, plus loads and
  // clears mixed in.
  task automatic run_phase(input int count, input logic [31:0] pitch,
                           input logic wall, input int idle);
    span_item_t it;
    int         r;
    drain_results();
    write_reg(REG_PITCH, pitch);
    write_reg(REG_WALL, {31'd0, wall});
    sender_idle = idle;
    repeat (count) begin
      it.kind      = OP_DRAW;
      it.location  = LOC_W'($urandom);
      it.load_data = DATA_W'($urandom);
      it.sx        = COORD_W'($urandom);
      it.sy        = COORD_W'($urandom);
      it.pos       = $urandom;
      it.step      = $urandom;
      it.len       = LEN_W'($urandom);
      r = $urandom_range(99);
      if (r < 14) begin
        it.kind = OP_TEX;
      end else if (r < 22) begin
        it.kind = OP_PAL;
        if ($urandom_range(7) != 0) it.location = LOC_W'($urandom_range(15));
      end else if (r < 26) begin
        it.kind = OP_CLEAR;
      end else if ($urandom_range(9) < 8) begin
        // drift is under 16 bytes per span, so reads stay in the windows
        if ($urandom_range(1) == 0)
          it.pos = $urandom_range(32'h0003_FFFF);
        else
          it.pos = 32'h00FF_FFFF - $urandom_range(32'h0001_FFFF);
        it.step = $urandom_range(32'h0000_1000) - 32'h0000_0800;
        it.len  = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(127, 17))
                                           : LEN_W'($urandom_range(16, 1));
      end else if (!it.pos[POS_W-1] && it.pos < 32'h0100_0000) begin
        // push noise past the store so it errors on the first pixel
        it.pos[24] = 1'b1;
      end
      send_item(it, 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: the receiver never stalls, so every strobe is a result
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && strobe) begin
      results_seen++;
      if (range_error === 1'b1) err_results++;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result at address %0h",
                                  pixel_address));
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_address", 32'(pixel_address), 32'(want.addr));
        check_field("color",         32'(color),         32'(want.color));
        check_field("range_error",   32'(range_error),   32'(want.err));
        check_field("last",          32'(last),          32'(want.last_flag));
        check_field("spans_total",   spans_total,        want.spans);
        check_field("pixels_total",  pixels_total,       want.pixels);
        check_field("errors_total",  errors_total,       want.errs);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    span_item_t it;
    span_row_t  row;
    pixel_t     typed_px;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Fill the low and high texel windows and every palette entry; no draw
    // below reads outside them. Wall is still off from reset.
    it = '0;
    for (int b = 0; b < TEXEL_BYTES; b++) begin
      if (b < FILL_LOW || b >= TEXEL_BYTES - FILL_HIGH) begin
        it.kind      = OP_TEX;
        it.location  = LOC_W'(b);
        it.load_data = DATA_W'($urandom);
        send_item(it, 1'b1);
      end
    end
    for (int c = 0; c < PAL_DEPTH; c++) begin
      it.kind      = OP_PAL;
      it.location  = LOC_W'(c);
      it.load_data = DATA_W'($urandom);
      send_item(it, 1'b1);
    end
    // draw with the wall off: accepted, but must produce nothing
    it.kind = OP_DRAW;
    it.pos  = '0;
    it.step = 32'h0000_1000;
    it.len  = 7'd10;
    send_item(it, 1'b1);

    drain_results();
    write_reg(REG_WALL, 32'd1);   // pitch left at its reset value

    // Directed table: typed rows carry their result, others use the shadow
    for (int i = 0; i < DIR_ROWS; i++) begin
      row          = dir_tab[i];
      it.kind      = row.kind;
      it.location  = row.location;
      it.load_data = row.load_data;
      it.sx        = row.sx;
      it.sy        = row.sy;
      it.pos       = row.pos;
      it.step      = row.step;
      it.len       = row.len;
      send_item(it, !row.typed);
      if (row.typed) begin
        typed_px = '{row.e_addr, row.e_color, row.e_err, 1'b1,
                     row.e_spans, row.e_pixels, row.e_errs};
        pending_pixels.push_back(typed_px);
      end
    end

    // Random phases; each starts from an empty pipeline so the registers
    // change only while idle. Pitch 0 stacks a span on one address, 2047
    // wraps the 21-bit address. The wall-off phase only checks silence.
    run_phase(30, 32'd1024, 1'b1, 36);
    run_phase(25, 32'd0,    1'b1, 36);
    run_phase(10, 32'd300,  1'b0, 45);
    run_phase(30, 32'd2047, 1'b1, 45);
    run_phase(25, 32'd1,    1'b1, 0);
    run_phase(25, 32'($urandom_range(1024, 1)), 1'b1, 0);

    drain_results();

    $display("Run covered %0d items (%0d draws); %0d pixel results checked,",
             items_sent, draws_sent, results_seen);
    $display("%0d of them range errors; pitches 256, 1024, 0, 2047, 1 and random,",
             err_results);
    $display("wall on and off, clears mid-stream.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pntcs_pkg.sv
sv/pntcs_ram.sv
sv/pntcs_front.sv
sv/pntcs_queue.sv
sv/pntcs_back.sv
sv/packed_nibble_texture_column_span.sv
verif/packed_nibble_texture_column_span_tb.sv
